/* rtl/core/u16u8_pkg.sv */
// Shared types, constants and the UTF-8 encode function of the UTF-16LE to UTF-8 transcoder.
`default_nettype none

package u16u8_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;  // 0xDC00..0xDFFF
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  // One encoded character: bytes go out from index 0 up to last_idx.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } u16u8_char_t;

  typedef struct packed {
    logic full;
    logic empty;
  } u16u8_fifo_stat_t;

  function automatic u16u8_char_t encode_point(input logic [20:0] c);
    u16u8_char_t e;
    e.bytes = '0;
    if (c[20:7] == '0) begin
      e.bytes[0] = {1'b0, c[6:0]};
      e.last_idx = 2'd0;
    end else if (c[20:11] == '0) begin
      e.bytes[0] = LEAD2 | {3'b000, c[10:6]};
      e.bytes[1] = CONT | {2'b00, c[5:0]};
      e.last_idx = 2'd1;
    end else if (c[20:16] == '0) begin
      e.bytes[0] = LEAD3 | {4'b0000, c[15:12]};
      e.bytes[1] = CONT | {2'b00, c[11:6]};
      e.bytes[2] = CONT | {2'b00, c[5:0]};
      e.last_idx = 2'd2;
    end else begin
      e.bytes[0] = LEAD4 | {5'b00000, c[20:18]};
      e.bytes[1] = CONT | {2'b00, c[17:12]};
      e.bytes[2] = CONT | {2'b00, c[11:6]};
      e.bytes[3] = CONT | {2'b00, c[5:0]};
      e.last_idx = 2'd3;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/utf16le_to_utf8_transcoder_top.sv */
// Top level of the UTF-16LE to UTF-8 transcoder.
//
// Takes one UTF-16 code unit per transfer and sends UTF-8 one byte per transfer, with
// char_done_o on the last byte of each character. The input side accepts a unit every
// cycle while the character queue (FifoDepth entries) has room; surrogate pairing and NUL
// termination happen at input time. The output side sends one byte per cycle while
// out_stall_i is low and characters are queued; a character takes 1 to 4 bytes. A
// character passes through the queue memory, its registered read port and the output
// byte register before its first byte appears. Unpaired surrogates are dropped, except a
// high surrogate that is the last unit of a buffer, which is sent as three bytes. After a
// NUL no bytes are sent until the last unit of the buffer has passed.
`default_nettype none

module utf16le_to_utf8_transcoder_top
  import u16u8_pkg::*;
#(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] code_unit_i,
  input  wire logic        final_unit_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             char_done_o
);

  u16u8_fifo_stat_t fifo_stat;
  u16u8_char_t      push_char, rd_char;
  logic             push, pop;

  u16u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_unit_i  (code_unit_i),
    .final_unit_i (final_unit_i),
    .fifo_stat_i  (fifo_stat),
    .push_o       (push),
    .push_char_o  (push_char)
  );

  u16u8_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_char_i (push_char),
    .pop_i       (pop),
    .rd_char_o   (rd_char),
    .stat_o      (fifo_stat)
  );

  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .cur_char_i  (rd_char),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .char_done_o (char_done_o)
  );

endmodule

`default_nettype wire

/* rtl/core/u16u8_front.sv */
// Front end: accepts code units, pairs surrogates, tracks NUL termination, encodes characters.
`default_nettype none

module u16u8_front
  import u16u8_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [15:0]      code_unit_i,
  input  wire logic             final_unit_i,
  input  wire u16u8_fifo_stat_t fifo_stat_i,
  output logic                  push_o,
  output u16u8_char_t           push_char_o
);

  logic [9:0] held_high_q, held_high_d;
  logic       held_valid_q, held_valid_d;
  logic       term_q, term_d;

  logic        accept;
  logic        is_high, is_low;
  logic        emit;
  logic [20:0] point;

  assign in_stall_o = fifo_stat_i.full;
  assign accept     = in_valid_i && !fifo_stat_i.full;
  assign is_high    = code_unit_i[15:10] == HIGH_SURR_TAG;
  assign is_low     = code_unit_i[15:10] == LOW_SURR_TAG;

  always_comb begin
    held_high_d  = held_high_q;
    held_valid_d = held_valid_q;
    term_d       = term_q;
    emit         = 1'b0;
    point        = {5'b00000, code_unit_i};
    if (accept) begin
      if (!term_q) begin
        held_valid_d = 1'b0;
        held_high_d  = '0;
        if (held_valid_q && is_low) begin
          point = SUPP_BASE + {1'b0, held_high_q, code_unit_i[9:0]};
          emit  = 1'b1;
        end else if (code_unit_i == '0) begin
          term_d = 1'b1;
        end else if (is_high && !final_unit_i) begin
          held_high_d  = code_unit_i[9:0];
          held_valid_d = 1'b1;
        end else if (!is_low) begin
          emit = 1'b1;
        end
      end
      // start a fresh buffer after the last unit
      if (final_unit_i) begin
        held_high_d  = '0;
        held_valid_d = 1'b0;
        term_d       = 1'b0;
      end
    end
  end

  assign push_o      = emit;
  assign push_char_o = encode_point(point);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_high_q  <= '0;
      held_valid_q <= 1'b0;
      term_q       <= 1'b0;
    end else begin
      held_high_q  <= held_high_d;
      held_valid_q <= held_valid_d;
      term_q       <= term_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/u16u8_fifo.sv */
// Character queue between front and back ends, with a registered read port.
`default_nettype none

module u16u8_fifo
  import u16u8_pkg::*;
#(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire u16u8_char_t  push_char_i,
  input  wire logic         pop_i,
  output u16u8_char_t       rd_char_o,
  output u16u8_fifo_stat_t  stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u16u8_char_t mem_q [Depth];
  u16u8_char_t rd_char_q;

  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign stat_o.full  = count_q == CntW'(Depth);
  assign stat_o.empty = count_q == '0;
  assign rd_char_o    = rd_char_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_char_i;
    end
    if (pop_i) begin
      rd_char_q <= mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/u16u8_back.sv */
// Back end: serializes queued characters into single UTF-8 bytes on the output channel.
`default_nettype none

module u16u8_back
  import u16u8_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire u16u8_fifo_stat_t fifo_stat_i,
  input  wire u16u8_char_t      cur_char_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  char_done_o
);

  logic       cur_valid_q, cur_valid_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       char_done_q;

  logic emit, is_last;

  assign emit    = cur_valid_q && (!out_valid_q || !out_stall_i);
  assign is_last = idx_q == cur_char_i.last_idx;
  // fetch the next character as the current one sends its final byte, or when none is held
  assign pop_o   = !fifo_stat_i.empty && (!cur_valid_q || (emit && is_last));

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (is_last) begin
        idx_d       = '0;
        cur_valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      cur_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q  <= cur_char_i.bytes[idx_q];
      char_done_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign char_done_o = char_done_q;

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the UTF-16LE to UTF-8 transcoder top level.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] data;
    logic       done;
  } utf8_byte_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [15:0] code_unit_i  = '0;
  logic        final_unit_i = 1'b0;
  logic        out_stall_i  = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        char_done_o;

  // Predicted transcoder state
  logic [9:0] held_bits  = '0;
  bit         high_held  = 1'b0;
  bit         nul_seen   = 1'b0;

  utf8_byte_t utf8_bytes_q[$];
  int unsigned mismatches = 0;
  int unsigned sent_units = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  utf16le_to_utf8_transcoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_unit_i  (code_unit_i),
    .final_unit_i (final_unit_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .char_done_o  (char_done_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic void push_byte(input logic [7:0] data, input logic done);
    utf8_byte_t b;
    b.data = data;
    b.done = done;
    utf8_bytes_q = {utf8_bytes_q, b};
  endfunction

  function automatic void push_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      push_byte({1'b0, cp[6:0]}, 1'b1);
    end else if (cp < 21'h800) begin
      push_byte({3'b110, cp[10:6]}, 1'b0);
      push_byte({2'b10, cp[5:0]}, 1'b1);
    end else if (cp < 21'h10000) begin
      push_byte({4'b1110, cp[15:12]}, 1'b0);
      push_byte({2'b10, cp[11:6]}, 1'b0);
      push_byte({2'b10, cp[5:0]}, 1'b1);
    end else begin
      push_byte({5'b11110, cp[20:18]}, 1'b0);
      push_byte({2'b10, cp[17:12]}, 1'b0);
      push_byte({2'b10, cp[11:6]}, 1'b0);
      push_byte({2'b10, cp[5:0]}, 1'b1);
    end
  endfunction

  function automatic void predict_unit(input logic [15:0] unit, input bit last);
    bit is_high;
    bit is_low;
    is_high = (unit >= 16'hD800) && (unit <= 16'hDBFF);
    is_low  = (unit >= 16'hDC00) && (unit <= 16'hDFFF);
    if (!nul_seen) begin
      if (high_held && is_low) begin
        push_code_point(21'h10000 + {1'b0, held_bits, 10'b0} + {11'b0, unit[9:0]});
        high_held = 1'b0;
        held_bits = '0;
      end else begin
        // a held high that is not completed is dropped here
        high_held = 1'b0;
        held_bits = '0;
        if (unit == 16'h0000) begin
          nul_seen = 1'b1;
        end else if (is_high && !last) begin
          held_bits = unit[9:0];
          high_held = 1'b1;
        end else if (!is_low) begin
          push_code_point({5'b0, unit});
        end
      end
    end
    if (last) begin
      held_bits = '0;
      high_held = 1'b0;
      nul_seen  = 1'b0;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_unit(input logic [15:0] unit, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    code_unit_i  <= unit;
    final_unit_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sent_units++;
    predict_unit(unit, last);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    utf8_byte_t exp_b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (utf8_bytes_q.size() == 0) begin
        $display("%0t: expected no byte, got byte %02h done %0b",
                 $time, out_byte_o, char_done_o);
        mismatches++;
      end else begin
        exp_b = utf8_bytes_q.pop_front();
        if (out_byte_o !== exp_b.data || char_done_o !== exp_b.done) begin
          $display("%0t: expected byte %02h done %0b, got byte %02h done %0b",
                   $time, exp_b.data, exp_b.done, out_byte_o, char_done_o);
          mismatches++;
        end
      end
    end
  end

  task automatic test_bmp_ranges();
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'h0041, 1'b1);
  endtask

  task automatic test_surrogate_pairs();
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hD83D, 1'b0);
    send_unit(16'hDE00, 1'b1);
  endtask

  task automatic test_broken_surrogates();
    send_unit(16'hDC00, 1'b0);  // stray low
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b0);  // drop held high, encode letter
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hD800, 1'b0);  // replace held high
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDABC, 1'b1);  // high on last unit goes out as three bytes
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDBFF, 1'b1);
  endtask

  task automatic test_nul_termination();
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'hDC00, 1'b0);  // ignored after NUL
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'h0000, 1'b1);
    send_unit(16'h0042, 1'b0);
  endtask

  task automatic test_random_text(input int unsigned count, input int unsigned idle_pct,
                                  input int unsigned stall_pct);
    int unsigned stop_at;
    int unsigned pick;
    logic [15:0] unit;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = sent_units + count;
    while (sent_units < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_unit(16'($urandom_range(16'h7F, 16'h01)), $urandom_range(15) == 0);
      end else if (pick < 45) begin
        send_unit(16'($urandom_range(16'h7FF, 16'h80)), $urandom_range(15) == 0);
      end else if (pick < 60) begin
        do unit = 16'($urandom_range(16'hFFFF, 16'h800));
        while (unit >= 16'hD800 && unit <= 16'hDFFF);
        send_unit(unit, $urandom_range(15) == 0);
      end else if (pick < 80) begin
        send_unit(16'($urandom_range(16'hDBFF, 16'hD800)), 1'b0);
        send_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), $urandom_range(15) == 0);
      end else if (pick < 85) begin
        send_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), $urandom_range(15) == 0);
      end else if (pick < 90) begin
        send_unit(16'($urandom_range(16'hDBFF, 16'hD800)), $urandom_range(3) == 0);
      end else if (pick < 93) begin
        send_unit(16'h0000, $urandom_range(7) == 0);
      end else begin
        send_unit(16'($urandom()), $urandom_range(15) == 0);
      end
    end
  endtask

  initial begin
    @(negedge clk_i);
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_bmp_ranges();
    test_surrogate_pairs();
    test_broken_surrogates();
    test_nul_termination();
    test_random_text(71, 0, 0);
    test_random_text(71, 55, 0);
    test_random_text(71, 0, 55);
    test_random_text(71, 27, 27);
    in_valid_i <= 1'b0;
    while (utf8_bytes_q.size() != 0) @(posedge clk_i);
    // allow the pipeline to show any stray bytes
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && utf8_bytes_q.size() == 0) begin
      $display("** utf16le_to_utf8_transcoder_top: PASSED **");
    end else begin
      $display("** utf16le_to_utf8_transcoder_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d bytes outstanding", $time, utf8_bytes_q.size());
    $display("** utf16le_to_utf8_transcoder_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
